// File: hw/rtl/ipmmt_pkg.sv
// Shared package for the IPv4 masked match table.
// Holds the table size, the item and entry types, the opcode and status codes.
// Used by the core and the compare unit; depends on nothing.
package ipmmt_pkg;

    localparam int ENTRIES = 1024;
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(ENTRIES);

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_ADD    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } status_t;

    typedef struct packed {
        op_t         opcode;
        logic [31:0] address;
        logic [31:0] mask;
    } req_item_t;

    typedef struct packed {
        logic    hit;
        status_t status;
    } rsp_item_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] address;
        logic [31:0] mask;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [4:0] {
        S_INIT  = 5'b00001,
        S_IDLE  = 5'b00010,
        S_SCAN  = 5'b00100,
        S_CLEAR = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

endpackage

// File: hw/rtl/ipv4_masked_match_table_core.sv
// Top level of the IPv4 masked match table: sequencer, entry RAM and result register.
// Depends on ipmmt_pkg, ipmmt_ram and ipmmt_cmp.
//
// Items arrive on req (req_valid, req_stall) and each gives one result item on
// rsp (rsp_valid, rsp_stall). An item is taken only while the block is idle;
// req_stall stays high while an item is at work.
// Lookup, add and remove walk the entry RAM one entry per cycle through one
// compare unit, reading one entry a cycle from the RAM's registered port. A walk
// stops at the first matching entry. A lookup of address zero or on an empty
// table, an add on a full table and a remove on an empty table skip the walk.
// Clear rewrites every entry, one per cycle.
// After reset the block sweeps every RAM entry to drop every valid mark and
// stalls its input meanwhile.
// The result waits in an output register; if rsp_stall holds it there when the
// next result is ready, the sequencer waits before going idle again.
module ipv4_masked_match_table_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  ipmmt_pkg::req_item_t  req,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output ipmmt_pkg::rsp_item_t  rsp
);

    ipmmt_pkg::state_t state_reg, state_next;
    ipmmt_pkg::req_item_t item_reg, item_next;
    ipmmt_pkg::rsp_item_t res_reg, res_next;
    ipmmt_pkg::rsp_item_t out_item_reg, out_item_next;
    logic out_valid_reg, out_valid_next;
    logic [ipmmt_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic issue_done_reg, issue_done_next;
    logic chk_valid_reg;
    logic [ipmmt_pkg::IDX_W-1:0] chk_idx_reg;
    logic [ipmmt_pkg::CNT_W-1:0] count_reg, count_next;

    logic wr_en;
    logic [ipmmt_pkg::IDX_W-1:0] wr_idx;
    ipmmt_pkg::entry_t wr_entry;
    logic rd_en;
    logic [ipmmt_pkg::ENTRY_W-1:0] rd_raw;
    ipmmt_pkg::entry_t rd_entry;
    logic match;

    ipmmt_ram #(
        .WIDTH(ipmmt_pkg::ENTRY_W),
        .DEPTH(ipmmt_pkg::ENTRIES)
    ) u_ram (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_idx),
        .wr_data(wr_entry),
        .rd_en  (rd_en),
        .rd_addr(idx_reg),
        .rd_data(rd_raw)
    );

    assign rd_entry = ipmmt_pkg::entry_t'(rd_raw);

    ipmmt_cmp u_cmp (
        .opcode (item_reg.opcode),
        .address(item_reg.address),
        .mask   (item_reg.mask),
        .entry  (rd_entry),
        .match  (match)
    );

    assign req_stall = (state_reg != ipmmt_pkg::S_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp = out_item_reg;

    always_comb
    begin
        state_next = state_reg;
        item_next = item_reg;
        res_next = res_reg;
        out_valid_next = out_valid_reg;
        out_item_next = out_item_reg;
        idx_next = idx_reg;
        issue_done_next = issue_done_reg;
        count_next = count_reg;
        wr_en = 1'b0;
        wr_idx = chk_idx_reg;
        wr_entry = '0;
        rd_en = 1'b0;

        if (out_valid_reg && !rsp_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ipmmt_pkg::S_INIT:
            begin
                wr_en = 1'b1;
                wr_idx = idx_reg;
                if (idx_reg == ipmmt_pkg::LAST_IDX)
                begin
                    idx_next = '0;
                    state_next = ipmmt_pkg::S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ipmmt_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    item_next = req;
                    idx_next = '0;
                    issue_done_next = 1'b0;
                    res_next.hit = 1'b0;
                    res_next.status = ipmmt_pkg::ST_DONE;
                    case (req.opcode)
                        ipmmt_pkg::OP_LOOKUP:
                        begin
                            if (req.address == 32'd0 || count_reg == '0)
                            begin
                                state_next = ipmmt_pkg::S_DONE;
                            end
                            else
                            begin
                                state_next = ipmmt_pkg::S_SCAN;
                            end
                        end
                        ipmmt_pkg::OP_ADD:
                        begin
                            if (count_reg == ipmmt_pkg::FULL_COUNT)
                            begin
                                res_next.status = ipmmt_pkg::ST_FULL;
                                state_next = ipmmt_pkg::S_DONE;
                            end
                            else
                            begin
                                state_next = ipmmt_pkg::S_SCAN;
                            end
                        end
                        ipmmt_pkg::OP_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next.status = ipmmt_pkg::ST_NOT_FOUND;
                                state_next = ipmmt_pkg::S_DONE;
                            end
                            else
                            begin
                                state_next = ipmmt_pkg::S_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = ipmmt_pkg::S_CLEAR;
                        end
                    endcase
                end
            end
            ipmmt_pkg::S_SCAN:
            begin
                rd_en = !issue_done_reg;
                if (!issue_done_reg)
                begin
                    if (idx_reg == ipmmt_pkg::LAST_IDX)
                    begin
                        issue_done_next = 1'b1;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                if (chk_valid_reg)
                begin
                    if (match)
                    begin
                        state_next = ipmmt_pkg::S_DONE;
                        case (item_reg.opcode)
                            ipmmt_pkg::OP_LOOKUP:
                            begin
                                res_next.hit = 1'b1;
                            end
                            ipmmt_pkg::OP_ADD:
                            begin
                                wr_en = 1'b1;
                                wr_entry.valid = 1'b1;
                                wr_entry.address = item_reg.address;
                                wr_entry.mask = item_reg.mask;
                                count_next = count_reg + 1'b1;
                            end
                            ipmmt_pkg::OP_REMOVE:
                            begin
                                wr_en = 1'b1;
                                wr_entry.valid = 1'b0;
                                wr_entry.address = rd_entry.address;
                                wr_entry.mask = rd_entry.mask;
                                count_next = count_reg - 1'b1;
                            end
                            default:
                            begin
                                res_next.hit = 1'b0;
                            end
                        endcase
                    end
                    else if (chk_idx_reg == ipmmt_pkg::LAST_IDX)
                    begin
                        state_next = ipmmt_pkg::S_DONE;
                        case (item_reg.opcode)
                            ipmmt_pkg::OP_ADD:
                                res_next.status = ipmmt_pkg::ST_FULL;
                            ipmmt_pkg::OP_REMOVE:
                                res_next.status = ipmmt_pkg::ST_NOT_FOUND;
                            default:
                                res_next.status = ipmmt_pkg::ST_DONE;
                        endcase
                    end
                end
            end
            ipmmt_pkg::S_CLEAR:
            begin
                wr_en = 1'b1;
                wr_idx = idx_reg;
                if (idx_reg == ipmmt_pkg::LAST_IDX)
                begin
                    idx_next = '0;
                    count_next = '0;
                    state_next = ipmmt_pkg::S_DONE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ipmmt_pkg::S_DONE:
            begin
                if (!out_valid_reg || !rsp_stall)
                begin
                    out_valid_next = 1'b1;
                    out_item_next = res_reg;
                    state_next = ipmmt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ipmmt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ipmmt_pkg::S_INIT;
            out_valid_reg <= 1'b0;
            idx_reg <= '0;
            issue_done_reg <= 1'b0;
            chk_valid_reg <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
            idx_reg <= idx_next;
            issue_done_reg <= issue_done_next;
            chk_valid_reg <= rd_en;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        res_reg <= res_next;
        out_item_reg <= out_item_next;
        chk_idx_reg <= idx_reg;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= ipmmt_pkg::FULL_COUNT)
        else $error("Entry count exceeds the table size.");

    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == ipmmt_pkg::S_INIT || state_reg == ipmmt_pkg::S_SCAN ||
                   state_reg == ipmmt_pkg::S_CLEAR))
        else $error("Entry RAM written outside a walk or sweep.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.hit) |-> (rsp.status == ipmmt_pkg::ST_DONE))
        else $error("A hit result carries an error status.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> (state_reg != ipmmt_pkg::S_IDLE))
        else $error("Accepted item did not start the sequencer.");

endmodule

// File: hw/rtl/ipmmt_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// Width and depth are parameters; no dependencies.
module ipmmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ram_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= ram_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/ipmmt_cmp.sv
// Shared compare unit: tests one stored entry against the current item.
// The test depends on the opcode. Depends on ipmmt_pkg.
module ipmmt_cmp (
    input  ipmmt_pkg::op_t    opcode,
    input  logic [31:0]       address,
    input  logic [31:0]       mask,
    input  ipmmt_pkg::entry_t entry,
    output logic              match
);

    always_comb
    begin
        case (opcode)
            ipmmt_pkg::OP_LOOKUP:
                match = entry.valid &&
                        ((address & entry.mask) == (entry.address & entry.mask));
            ipmmt_pkg::OP_ADD:
                match = !entry.valid;
            ipmmt_pkg::OP_REMOVE:
                match = entry.valid && (entry.address == address) && (entry.mask == mask);
            default:
                match = 1'b0;
        endcase
    end

endmodule
